@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-qualified property wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/pdj_pkg.sv @@
// ----------------------------------------------------------------------------
// pdj_pkg
// Widths, codes and the key decoder of the joint PD torque block.
// ----------------------------------------------------------------------------
package pdj_pkg;

  localparam int JOINTS = 7;
  localparam int JIDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  localparam int KIND_W     = 2;
  localparam int KEY_W      = 8;
  localparam int JOINT_W    = 3;
  localparam int Q_W        = 20;  // Q4.16 angles, rates, torques
  localparam int GAIN_W     = 16;  // Q4.12 gains
  localparam int ALPHA_W    = 17;  // Q1.16 weight, used up to 1.0
  localparam int STEP_W     = 16;
  localparam int LIM_W      = 19;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;

  localparam logic [ALPHA_W-1:0] ONE_Q16 = 17'h10000;

  typedef enum logic [KIND_W-1:0] {
    KIND_KEY    = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_PRESET = 2'd2,
    KIND_RSVD   = 2'd3
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLEW_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_JOG_STEP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TORQUE_LIM = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_LIM   = 3'd6;

  localparam logic [KEY_W-1:0] KEY_STOP_LO = 8'h78;  // 'x'
  localparam logic [KEY_W-1:0] KEY_STOP_UP = 8'h58;  // 'X'
  localparam logic [KEY_W-1:0] CASE_OFFSET = 8'h20;
  localparam int               JOG_KEYS_N  = 7;

  // q w e r t y u -> joints 0..6
  localparam logic [KEY_W-1:0] JOG_KEYS [JOG_KEYS_N] =
    '{8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75};

  typedef struct packed {
    logic               hit;
    logic               up;
    logic [JOINT_W-1:0] idx;
  } key_dec_t;

  function automatic key_dec_t key_decode(input logic [KEY_W-1:0] k);
    key_dec_t d;
    d = '0;
    for (int i = 0; i < JOG_KEYS_N; i++) begin
      if (k == JOG_KEYS[i]) begin
        d.hit = 1'b1;
        d.up  = 1'b0;
        d.idx = JOINT_W'(i);
      end
      if (k == (JOG_KEYS[i] - CASE_OFFSET)) begin
        d.hit = 1'b1;
        d.up  = 1'b1;
        d.idx = JOINT_W'(i);
      end
    end
    return d;
  endfunction

endpackage

@@ rtl/core/pdj_item_if.sv @@
// ----------------------------------------------------------------------------
// pdj_item_if
// Input channel: key, tick and goal preset transactions.
// ----------------------------------------------------------------------------
interface pdj_item_if;
  logic                              valid;
  logic                              ready;
  logic [pdj_pkg::KIND_W-1:0]        kind;
  logic [pdj_pkg::KEY_W-1:0]         key_code;
  logic [pdj_pkg::JOINT_W-1:0]       joint;
  logic signed [pdj_pkg::Q_W-1:0]    position;
  logic signed [pdj_pkg::Q_W-1:0]    velocity;

  modport source (output valid, kind, key_code, joint, position, velocity, input ready);
  modport sink   (input valid, kind, key_code, joint, position, velocity, output ready);
endinterface

@@ rtl/core/pdj_result_if.sv @@
// ----------------------------------------------------------------------------
// pdj_result_if
// Output channel: one torque command per tick transaction on a valid joint.
// ----------------------------------------------------------------------------
interface pdj_result_if;
  logic                              valid;
  logic                              ready;
  logic [pdj_pkg::JOINT_W-1:0]       joint_out;
  logic signed [pdj_pkg::Q_W-1:0]    torque;
  logic                              stopped;

  modport source (output valid, joint_out, torque, stopped, input ready);
  modport sink   (input valid, joint_out, torque, stopped, output ready);
endinterface

@@ rtl/core/joint_pd_torque_with_jog_goals.sv @@
// ----------------------------------------------------------------------------
// joint_pd_torque_with_jog_goals
// Per-joint PD position controller with jog goals, slew limit and IIR output.
// ----------------------------------------------------------------------------
// Usage:
//   cmd  carries one transaction per item: a key event, a control tick or a
//        goal preset. cmd.ready is high only while the sequencer is idle.
//   rsp  carries one torque command for each tick on a valid joint.
//   cfg  plain write port (cfg_we, cfg_index, cfg_data); write only while idle.
// Steps per item:
//   tick:           result valid at the end; one 18x28 multiplier
//                   is reused for P, D and both filter terms, then an add
//                   and a saturate step.
//   key event:      goals are jogged and clamped one joint per cycle through
//                   a single adder/compare.
//   preset, stop key, halted tick, ignored items: straight to the hand-off step.
// Reset: registers take their defaults, goals, smoothed goals and filter
//   state clear to zero, halt clears.
// Stall: the result sits in an output register; the block takes the next
//   item meanwhile, and only a second tick waits in its last step until the
//   register is free.
// ----------------------------------------------------------------------------
module joint_pd_torque_with_jog_goals (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pdj_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pdj_pkg::CFG_DATA_W-1:0]  cfg_data,
  pdj_item_if.sink                        cmd,
  pdj_result_if.source                    rsp
);
  import pdj_pkg::*;

  // sequencer, one-hot
  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_KEY  = 10'b00_0000_0010,  // jog + clamp sweep over joints
    S_SLEW = 10'b00_0000_0100,  // slew-limited smoothed goal update
    S_MP   = 10'b00_0000_1000,  // kp * (sg - pos)
    S_MD   = 10'b00_0001_0000,  // kd * (-vel)
    S_ML   = 10'b00_0010_0000,  // (1 - alpha) * last_torque
    S_MW   = 10'b00_0100_0000,  // alpha * want
    S_ACC  = 10'b00_1000_0000,  // sum filter terms
    S_SAT  = 10'b01_0000_0000,  // shift, saturate, store
    S_EMIT = 10'b10_0000_0000   // hand off to output register
  } state_t;

  localparam int ERR_W  = Q_W + 1;          // difference of two Q4.16 values
  localparam int MB_W   = 28;               // multiplier signed operand
  localparam int PROD_W = ALPHA_W + 1 + MB_W;
  localparam int PD_W   = ERR_W + GAIN_W - 12;  // one PD term after >>12
  localparam int WANT_W = PD_W + 1;
  localparam int F_W    = PROD_W - 16;

  state_t state;

  // configuration
  logic [GAIN_W-1:0]  prop_gain;
  logic [GAIN_W-1:0]  deriv_gain;
  logic [ALPHA_W-1:0] smooth_alpha;
  logic [STEP_W-1:0]  goal_slew_step;
  logic [STEP_W-1:0]  jog_step;
  logic [LIM_W-1:0]   torque_limit;
  logic [LIM_W-1:0]   goal_limit;

  // per-joint state
  logic signed [Q_W-1:0] goal          [JOINTS];
  logic signed [Q_W-1:0] smoothed_goal [JOINTS];
  logic signed [Q_W-1:0] last_torque   [JOINTS];
  logic                  halted;

  // item and work registers
  logic [JIDX_W-1:0]       j_r;
  logic signed [Q_W-1:0]   pos_r;
  logic signed [Q_W-1:0]   vel_r;
  logic                    jog_hit;
  logic                    jog_up;
  logic [JIDX_W-1:0]       jog_idx;
  logic [JIDX_W-1:0]       idx;
  logic signed [Q_W-1:0]   sg_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [WANT_W-1:0] want_r;
  logic signed [PROD_W-1:0] acc_r;
  logic                    res_pend;
  logic signed [Q_W-1:0]   res_torque;
  logic                    res_stopped;

  // output register
  logic                    out_valid;
  logic [JOINT_W-1:0]      out_joint;
  logic signed [Q_W-1:0]   out_torque;
  logic                    out_stopped;

  logic accept;
  logic out_free;
  logic j_ok;
  key_dec_t kd;

  assign cmd.ready     = (state == S_IDLE);
  assign accept        = cmd.valid && cmd.ready;
  assign out_free      = !out_valid || rsp.ready;
  assign j_ok          = 32'(cmd.joint) < JOINTS;
  assign kd            = key_decode(cmd.key_code);
  assign rsp.valid     = out_valid;
  assign rsp.joint_out = out_joint;
  assign rsp.torque    = out_torque;
  assign rsp.stopped   = out_stopped;

  // single read port per store
  logic [JIDX_W-1:0]     rd_idx;
  logic signed [Q_W-1:0] goal_rd;
  logic signed [Q_W-1:0] sm_rd;
  logic signed [Q_W-1:0] lt_rd;

  assign rd_idx  = (state == S_KEY) ? idx : j_r;
  assign goal_rd = goal[rd_idx];
  assign sm_rd   = smoothed_goal[j_r];
  assign lt_rd   = last_torque[j_r];

  // jog and clamp of one goal
  logic signed [ERR_W-1:0] jog_ext;
  logic signed [ERR_W-1:0] jog_term;
  logic signed [ERR_W-1:0] goal_sum;
  logic signed [ERR_W-1:0] glim;
  logic signed [Q_W-1:0]   goal_clamped;

  assign jog_ext  = $signed({{(ERR_W-STEP_W){1'b0}}, jog_step});
  assign jog_term = (jog_hit && idx == jog_idx) ? (jog_up ? jog_ext : -jog_ext)
                                                : '0;
  assign goal_sum = ERR_W'(goal_rd) + jog_term;
  assign glim     = $signed({{(ERR_W-LIM_W){1'b0}}, goal_limit});

  always_comb begin
    priority if (goal_sum > glim) begin
      goal_clamped = glim[Q_W-1:0];
    end else if (goal_sum < -glim) begin
      goal_clamped = Q_W'(-glim);
    end else begin
      goal_clamped = goal_sum[Q_W-1:0];
    end
  end

  // slew limit
  logic signed [ERR_W-1:0] diff;
  logic signed [ERR_W-1:0] slew;
  logic signed [ERR_W-1:0] diff_c;
  logic signed [ERR_W-1:0] sg_sum;

  assign diff   = ERR_W'(goal_rd) - ERR_W'(sm_rd);
  assign slew   = $signed({{(ERR_W-STEP_W){1'b0}}, goal_slew_step});
  assign sg_sum = ERR_W'(sm_rd) + diff_c;  // lies between sm and goal

  always_comb begin
    priority if (diff > slew) begin
      diff_c = slew;
    end else if (diff < -slew) begin
      diff_c = -slew;
    end else begin
      diff_c = diff;
    end
  end

  // filter weights; alpha above one acts as one
  logic [ALPHA_W-1:0] alpha_eff;
  logic [ALPHA_W-1:0] beta;

  assign alpha_eff = (smooth_alpha > ONE_Q16) ? ONE_Q16 : smooth_alpha;
  assign beta      = ONE_Q16 - alpha_eff;

  // shared multiplier: unsigned 17b times signed 28b
  logic [ALPHA_W-1:0]       mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W-1:0]  nvel;

  assign err   = ERR_W'(sg_r) - ERR_W'(pos_r);
  assign nvel  = -ERR_W'(vel_r);
  assign mul_p = $signed({1'b0, mul_a}) * mul_b;

  always_comb begin
    unique case (state)
      S_MP: begin
        mul_a = ALPHA_W'(prop_gain);
        mul_b = MB_W'(err);
      end
      S_MD: begin
        mul_a = ALPHA_W'(deriv_gain);
        mul_b = MB_W'(nvel);
      end
      S_ML: begin
        mul_a = beta;
        mul_b = MB_W'(lt_rd);
      end
      S_MW: begin
        mul_a = alpha_eff;
        mul_b = MB_W'(want_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // PD term of the last product (floor shift by 12)
  logic signed [WANT_W-1:0] pd_term;
  assign pd_term = WANT_W'($signed(prod_r[PD_W+11:12]));

  // filter output, saturated
  logic signed [F_W-1:0] f_raw;
  logic signed [F_W-1:0] tlim;
  logic signed [Q_W-1:0] f_sat;

  assign f_raw = acc_r[PROD_W-1:16];
  assign tlim  = $signed({{(F_W-LIM_W){1'b0}}, torque_limit});

  always_comb begin
    priority if (f_raw > tlim) begin
      f_sat = tlim[Q_W-1:0];
    end else if (f_raw < -tlim) begin
      f_sat = Q_W'(-tlim);
    end else begin
      f_sat = f_raw[Q_W-1:0];
    end
  end

  // control, configuration and joint state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      halted         <= 1'b0;
      res_pend       <= 1'b0;
      out_valid      <= 1'b0;
      prop_gain      <= 16'd8192;
      deriv_gain     <= 16'd2048;
      smooth_alpha   <= 17'd6554;
      goal_slew_step <= 16'd655;
      jog_step       <= 16'd1966;
      torque_limit   <= 19'd327680;
      goal_limit     <= 19'd205887;
      for (int i = 0; i < JOINTS; i++) begin
        goal[i]          <= '0;
        smoothed_goal[i] <= '0;
        last_torque[i]   <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PROP_GAIN:  prop_gain      <= cfg_data[GAIN_W-1:0];
          REG_DERIV_GAIN: deriv_gain     <= cfg_data[GAIN_W-1:0];
          REG_ALPHA:      smooth_alpha   <= cfg_data[ALPHA_W-1:0];
          REG_SLEW_STEP:  goal_slew_step <= cfg_data[STEP_W-1:0];
          REG_JOG_STEP:   jog_step       <= cfg_data[STEP_W-1:0];
          REG_TORQUE_LIM: torque_limit   <= cfg_data[LIM_W-1:0];
          REG_GOAL_LIM:   goal_limit     <= cfg_data[LIM_W-1:0];
          default: ;
        endcase
      end

      // output register: load from EMIT, else clear once taken
      if (state == S_EMIT && res_pend && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      // res_pend is already clear whenever the sequencer is idle
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (kind_t'(cmd.kind))
              KIND_KEY: begin
                if (halted) begin
                  state <= S_EMIT;
                end else if (cmd.key_code == KEY_STOP_LO || cmd.key_code == KEY_STOP_UP) begin
                  halted <= 1'b1;
                  state  <= S_EMIT;
                end else begin
                  state <= S_KEY;
                end
              end
              KIND_PRESET: begin
                state <= S_EMIT;
                if (!halted && j_ok) begin
                  goal[JIDX_W'(cmd.joint)] <= cmd.position;
                end
              end
              KIND_TICK: begin
                res_pend <= j_ok && halted;
                if (j_ok && !halted) begin
                  state <= S_SLEW;
                end else begin
                  state <= S_EMIT;
                end
              end
              default: state <= S_EMIT;
            endcase
          end
        end
        S_KEY: begin
          goal[idx] <= goal_clamped;
          if (idx == JIDX_W'(JOINTS - 1)) begin
            state <= S_EMIT;
          end
        end
        S_SLEW: begin
          smoothed_goal[j_r] <= sg_sum[Q_W-1:0];
          state              <= S_MP;
        end
        S_MP:  state <= S_MD;
        S_MD:  state <= S_ML;
        S_ML:  state <= S_MW;
        S_MW:  state <= S_ACC;
        S_ACC: state <= S_SAT;
        S_SAT: begin
          last_torque[j_r] <= f_sat;
          res_pend         <= 1'b1;
          state            <= S_EMIT;
        end
        S_EMIT: begin
          if (!res_pend) begin
            state <= S_IDLE;
          end else if (out_free) begin
            res_pend  <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (accept) begin
      j_r         <= JIDX_W'(cmd.joint);
      pos_r       <= cmd.position;
      vel_r       <= cmd.velocity;
      jog_hit     <= kd.hit && (32'(kd.idx) < JOINTS);
      jog_up      <= kd.up;
      jog_idx     <= JIDX_W'(kd.idx);
      idx         <= '0;
      res_torque  <= '0;   // halted tick result
      res_stopped <= 1'b1;
    end
    if (state == S_KEY) begin
      idx <= idx + 1'b1;
    end
    if (state == S_SLEW) begin
      sg_r <= sg_sum[Q_W-1:0];
    end
    if (state == S_MD) begin
      want_r <= pd_term;
    end
    if (state == S_ML) begin
      want_r <= want_r + pd_term;
    end
    if (state == S_MW) begin
      acc_r <= prod_r;
    end
    if (state == S_ACC) begin
      acc_r <= acc_r + prod_r;
    end
    if (state == S_SAT) begin
      res_torque  <= f_sat;
      res_stopped <= 1'b0;
    end
    if (state == S_EMIT && res_pend && out_free) begin
      out_joint   <= JOINT_W'(j_r);
      out_torque  <= res_torque;
      out_stopped <= res_stopped;
    end
  end

endmodule

@@ rtl/core/pdj_checker.sv @@
// ----------------------------------------------------------------------------
// pdj_checker
// Port-level checks of the joint PD torque block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdj_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              cmd_valid,
  input logic                              cmd_ready,
  input logic                              rsp_valid,
  input logic                              rsp_ready,
  input logic [pdj_pkg::JOINT_W-1:0]       rsp_joint_out,
  input logic signed [pdj_pkg::Q_W-1:0]    rsp_torque,
  input logic                              rsp_stopped
);
  import pdj_pkg::*;

  // a stopped result was delivered; halt lasts until reset
  logic seen_stop;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_stop <= 1'b0;
    end else if (rsp_valid && rsp_ready && rsp_stopped) begin
      seen_stop <= 1'b1;
    end
  end

  `ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_torque) && $stable(rsp_stopped) && $stable(rsp_joint_out), "stalled result changed")
  `ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready, "ready right after a transaction")
  `ASSERT_IMPL(a_stop_zero, rsp_valid && rsp_stopped, rsp_torque == '0, "torque nonzero when stopped")
  `ASSERT_IMPL(a_stop_sticky, rsp_valid && seen_stop, rsp_stopped, "halt cleared without reset")
  `ASSERT_IMPL(a_joint_range, rsp_valid, 32'(rsp_joint_out) < JOINTS, "result joint out of range")

endmodule

bind joint_pd_torque_with_jog_goals pdj_checker u_pdj_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_joint_out (rsp.joint_out),
  .rsp_torque    (rsp.torque),
  .rsp_stopped   (rsp.stopped)
);

@@ test/joint_pd_torque_with_jog_goals_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// joint_pd_torque_with_jog_goals_test
// Self-checking bench for the joint PD torque block. Key, preset and tick
// transactions are driven into the cmd channel with random gaps. A local
// model of the controller predicts each torque command, and the rsp channel
// is checked field by field under random back-pressure, over several
// register settings that include both extremes.
// ----------------------------------------------------------------------------
module joint_pd_torque_with_jog_goals_test;
  import pdj_pkg::*;

  // Run limit: about 1000 items at their worst case, plus settle windows,
  // taken several times over.
  localparam int LIMIT_CYCLES  = 200000;
  // Longest item: a key jog over all joints, or a tick.
  localparam int SETTLE_CYCLES = 16;
  localparam int REG_COUNT     = 7;
  localparam int MAX_REPORTS   = 200;

  localparam int     GAIN_FRAC  = 12;  // Q4.12 gains
  localparam int     ALPHA_FRAC = 16;  // Q1.16 filter weight
  localparam longint Q_ONE      = 65536;

  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  // Key bytes that decode to nothing.
  localparam logic [KEY_W-1:0] KEY_NONE     = 8'h00;
  localparam logic [KEY_W-1:0] KEY_UNKNOWN  = 8'h61;  // 'a'
  localparam logic [KEY_W-1:0] KEY_ALL_ONES = 8'hFF;

  typedef struct packed {
    kind_t                  kind;
    logic [KEY_W-1:0]       key_code;
    logic [JOINT_W-1:0]     joint;
    logic signed [Q_W-1:0]  position;
    logic signed [Q_W-1:0]  velocity;
  } cmd_item_t;

  typedef struct packed {
    logic [JOINT_W-1:0]     joint;
    logic signed [Q_W-1:0]  torque;
    logic                   stopped;
  } torque_cmd_t;

  typedef struct {
    int prop_gain;
    int deriv_gain;
    int alpha;
    int slew_step;
    int jog_step;
    int torque_limit;
    int goal_limit;
  } ctrl_cfg_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  pdj_item_if   cmd ();
  pdj_result_if rsp ();

  joint_pd_torque_with_jog_goals uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Controller model state: mirrors the block's registers and per-joint state
  // --------------------------------------------------------------------------
  ctrl_cfg_t              active_cfg;
  logic signed [Q_W-1:0]  goal_q        [JOINTS];
  logic signed [Q_W-1:0]  smooth_goal_q [JOINTS];
  logic signed [Q_W-1:0]  filt_torque_q [JOINTS];
  logic                   halted_q;

  torque_cmd_t torque_expected [$];
  torque_cmd_t torque_head;
  int          torque_errors = 0;
  int          cycle_count   = 0;

  // Idle percentages per side; zero gives a stretch with no gaps.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_left    = 0;

  function automatic longint clamp_sym(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Advance the model by one accepted transaction; a tick on a valid joint
  // queues the torque command the block must return.
  task automatic predict_controller(input cmd_item_t it);
    longint      pos, vel, diff, sg, a, p, d, f, g;
    int          j, jog_idx, dir;
    torque_cmd_t r;
    pos = longint'($signed(it.position));
    vel = longint'($signed(it.velocity));
    j   = it.joint;
    case (it.kind)
      KIND_KEY: begin
        if (halted_q) return;
        if (it.key_code == KEY_STOP_LO || it.key_code == KEY_STOP_UP) begin
          halted_q = 1'b1;
          return;
        end
        jog_idx = -1;
        dir     = 0;
        for (int i = 0; i < JOG_KEYS_N; i++) begin
          if (it.key_code == JOG_KEYS[i]) begin
            jog_idx = i;
            dir     = -1;
          end
          if (it.key_code == JOG_KEYS[i] - CASE_OFFSET) begin
            jog_idx = i;
            dir     = 1;
          end
        end
        // Every goal is clamped, jogged or not; the sum is formed wide.
        for (int i = 0; i < JOINTS; i++) begin
          g = longint'(goal_q[i]);
          if (i == jog_idx) g += dir * longint'(active_cfg.jog_step);
          g = clamp_sym(g, active_cfg.goal_limit);
          goal_q[i] = g[Q_W-1:0];
        end
      end
      KIND_PRESET: begin
        if (!halted_q && j < JOINTS) goal_q[j] = it.position;
      end
      KIND_TICK: begin
        if (j >= JOINTS) return;
        r.joint = it.joint;
        if (halted_q) begin
          r.torque  = '0;
          r.stopped = 1'b1;
        end else begin
          diff = clamp_sym(longint'(goal_q[j]) - longint'(smooth_goal_q[j]),
                           active_cfg.slew_step);
          sg = longint'(smooth_goal_q[j]) + diff;
          smooth_goal_q[j] = sg[Q_W-1:0];
          a = (active_cfg.alpha > Q_ONE) ? Q_ONE : longint'(active_cfg.alpha);
          p = (longint'(active_cfg.prop_gain) * (sg - pos)) >>> GAIN_FRAC;
          d = (longint'(active_cfg.deriv_gain) * (-vel)) >>> GAIN_FRAC;
          f = (a * (p + d) + (Q_ONE - a) * longint'(filt_torque_q[j])) >>> ALPHA_FRAC;
          f = clamp_sym(f, active_cfg.torque_limit);
          filt_torque_q[j] = f[Q_W-1:0];
          r.torque  = f[Q_W-1:0];
          r.stopped = 1'b0;
        end
        torque_expected.push_back(r);
      end
      default: ;  // reserved kind: ignored
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Item construction
  // --------------------------------------------------------------------------
  function automatic cmd_item_t make_item(input kind_t k, input logic [KEY_W-1:0] key,
                                          input int joint, input longint pos,
                                          input longint vel);
    cmd_item_t it;
    it.kind     = k;
    it.key_code = key;
    it.joint    = JOINT_W'(joint);
    it.position = Q_W'(pos);
    it.velocity = Q_W'(vel);
    return it;
  endfunction

  function automatic logic [KEY_W-1:0] jog_key(input int joint, input bit raise);
    return raise ? JOG_KEYS[joint] - CASE_OFFSET : JOG_KEYS[joint];
  endfunction

  // Mostly ticks and jogs on valid joints; positions either land near the
  // current goal (so the PD loop sees realistic errors) or anywhere.
  function automatic cmd_item_t random_item(input bit allow_stop);
    cmd_item_t it;
    int        pick, j;
    pick = $urandom_range(99);
    if (pick < 50) it.kind = KIND_TICK;
    else if (pick < 78) it.kind = KIND_KEY;
    else if (pick < 95) it.kind = KIND_PRESET;
    else it.kind = KIND_RSVD;

    if ($urandom_range(99) < 75) begin
      it.key_code = jog_key($urandom_range(JOG_KEYS_N - 1), $urandom_range(1));
    end else begin
      it.key_code = KEY_W'($urandom);
    end
    // Halt is saved for the last phase; nudge stray stop bytes to a jog key.
    if (!allow_stop && (it.key_code == KEY_STOP_LO || it.key_code == KEY_STOP_UP))
      it.key_code = it.key_code + 1'b1;

    if ($urandom_range(99) < 8) it.joint = JOINT_W'(JOINTS);
    else it.joint = JOINT_W'($urandom_range(JOINTS - 1));

    j = (it.joint < JOINTS) ? it.joint : 0;
    if ($urandom_range(1)) begin
      it.position = Q_W'($urandom);
    end else begin
      it.position = Q_W'(longint'(goal_q[j]) + longint'($urandom_range(16383)) - 8192);
    end
    if ($urandom_range(1)) begin
      it.velocity = Q_W'($urandom);
    end else begin
      it.velocity = Q_W'(longint'($urandom_range(4095)) - 2048);
    end
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Driver side
  // --------------------------------------------------------------------------
  // Send one transaction; returns at the accepting edge with valid still high
  // so back-to-back items never drop valid within a step.
  task automatic send_item(input cmd_item_t it);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    cmd.valid    <= 1'b1;
    cmd.kind     <= it.kind;
    cmd.key_code <= it.key_code;
    cmd.joint    <= it.joint;
    cmd.position <= it.position;
    cmd.velocity <= it.velocity;
    do @(posedge clk); while (!cmd.ready);
    predict_controller(it);
  endtask

  task automatic run_random(input int count, input bit allow_stop);
    repeat (count) send_item(random_item(allow_stop));
  endtask

  // Stop sending, let every expected result drain, then give key jogs that
  // produce no result time to finish before anything else happens.
  task automatic drain_and_settle();
    cmd.valid <= 1'b0;
    while (torque_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all registers, one per cycle; only called with the block idle.
  task automatic load_settings(input ctrl_cfg_t c);
    int vals [REG_COUNT];
    vals[REG_PROP_GAIN]  = c.prop_gain;
    vals[REG_DERIV_GAIN] = c.deriv_gain;
    vals[REG_ALPHA]      = c.alpha;
    vals[REG_SLEW_STEP]  = c.slew_step;
    vals[REG_JOG_STEP]   = c.jog_step;
    vals[REG_TORQUE_LIM] = c.torque_limit;
    vals[REG_GOAL_LIM]   = c.goal_limit;
    for (int i = 0; i < REG_COUNT; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= CFG_DATA_W'(vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    active_cfg = c;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts on rsp.ready
  // --------------------------------------------------------------------------
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else if (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct) begin
        stall_left = $urandom_range(3, 1) - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: each rsp transaction against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (torque_expected.size() == 0) begin
        torque_errors++;
        if (torque_errors <= MAX_REPORTS)
          $display("%0t: unexpected torque transaction joint_out=%0d torque=%0d stopped=%0d",
                   $time, rsp.joint_out, $signed(rsp.torque), rsp.stopped);
      end else begin
        torque_head = torque_expected.pop_front();
        if (rsp.joint_out !== torque_head.joint) begin
          torque_errors++;
          if (torque_errors <= MAX_REPORTS)
            $display("%0t: joint_out expected %0d actual %0d",
                     $time, torque_head.joint, rsp.joint_out);
        end
        if (rsp.torque !== torque_head.torque) begin
          torque_errors++;
          if (torque_errors <= MAX_REPORTS)
            $display("%0t: torque (joint %0d) expected %0d actual %0d", $time,
                     torque_head.joint, $signed(torque_head.torque), $signed(rsp.torque));
        end
        if (rsp.stopped !== torque_head.stopped) begin
          torque_errors++;
          if (torque_errors <= MAX_REPORTS)
            $display("%0t: stopped expected %0d actual %0d",
                     $time, torque_head.stopped, rsp.stopped);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset defaults: extremes of position and velocity, jog in both
  // directions, unclamped presets, clamp on an unknown key, wide jog sums,
  // out-of-range joints and the reserved kind.
  task automatic test_directed_defaults();
    send_idle_pct = 30;
    recv_idle_pct = 30;
    send_item(make_item(KIND_TICK,   KEY_NONE, 0, 0, 0));
    send_item(make_item(KIND_PRESET, KEY_NONE, 0, Q_ONE, 0));
    send_item(make_item(KIND_TICK,   KEY_NONE, 0, 0, 0));
    send_item(make_item(KIND_TICK,   KEY_NONE, 0, Q_MAX, Q_MIN));
    send_item(make_item(KIND_TICK,   KEY_NONE, 0, Q_MIN, Q_MAX));
    send_item(make_item(KIND_KEY,    jog_key(0, 1), 0, 0, 0));
    send_item(make_item(KIND_KEY,    jog_key(6, 0), 0, 0, 0));
    send_item(make_item(KIND_TICK,   KEY_NONE, 6, 0, 1000));
    // Preset beyond the goal limit is kept as is until the next key.
    send_item(make_item(KIND_PRESET, KEY_NONE, 1, Q_MAX, 0));
    send_item(make_item(KIND_TICK,   KEY_NONE, 1, Q_MIN, 0));
    send_item(make_item(KIND_KEY,    KEY_UNKNOWN, 0, 0, 0));
    send_item(make_item(KIND_TICK,   KEY_NONE, 1, 0, 0));
    // Jog past the limit from just inside it, and from the most negative goal.
    send_item(make_item(KIND_PRESET, KEY_NONE, 2, active_cfg.goal_limit - 100, 0));
    send_item(make_item(KIND_KEY,    jog_key(2, 1), 0, 0, 0));
    send_item(make_item(KIND_PRESET, KEY_NONE, 3, Q_MIN, 0));
    send_item(make_item(KIND_KEY,    jog_key(3, 0), 0, 0, 0));
    send_item(make_item(KIND_TICK,   KEY_NONE, 3, 0, Q_MIN));
    // Joint index past the last joint: ignored, no result.
    send_item(make_item(KIND_PRESET, KEY_NONE, JOINTS, Q_ONE, 0));
    send_item(make_item(KIND_TICK,   KEY_NONE, JOINTS, 0, 0));
    send_item(make_item(KIND_RSVD,   KEY_ALL_ONES, 0, Q_MAX, Q_MAX));
    send_item(make_item(KIND_KEY,    KEY_ALL_ONES, 0, 0, 0));
    send_item(make_item(KIND_KEY,    KEY_NONE, 0, 0, 0));
    send_item(make_item(KIND_TICK,   KEY_NONE, 2, 0, 0));
    send_item(make_item(KIND_TICK,   KEY_NONE, 5, Q_MAX, Q_MAX));
  endtask

  task automatic test_random_defaults();
    send_idle_pct = 30;
    recv_idle_pct = 30;
    run_random(150, 1'b0);
  endtask

  // All registers zero: no gain, no slew, zero limits, filter frozen.
  task automatic test_zero_settings();
    ctrl_cfg_t c;
    c = '{0, 0, 0, 0, 0, 0, 0};
    drain_and_settle();
    load_settings(c);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(80, 1'b0);
  endtask

  // All registers at their top values; alpha exactly one.
  task automatic test_max_settings();
    ctrl_cfg_t c;
    c = '{65535, 65535, 65536, 65535, 65535, 524287, 524287};
    drain_and_settle();
    load_settings(c);
    send_idle_pct = 50;
    recv_idle_pct = 20;
    run_random(120, 1'b0);
  endtask

  // Alpha above one must behave as one; the field's top value included.
  task automatic test_alpha_above_one();
    ctrl_cfg_t c;
    c = '{8192, 2048, 131071, 655, 1966, 327680, 205887};
    drain_and_settle();
    load_settings(c);
    send_idle_pct = 20;
    recv_idle_pct = 50;
    run_random(40, 1'b0);
    c.alpha = $urandom_range(131070, 65537);
    drain_and_settle();
    load_settings(c);
    run_random(40, 1'b0);
  endtask

  task automatic test_random_settings();
    ctrl_cfg_t c;
    repeat (4) begin
      c.prop_gain    = $urandom_range(65535);
      c.deriv_gain   = $urandom_range(65535);
      c.alpha        = $urandom_range(65536);
      c.slew_step    = $urandom_range(65535);
      c.jog_step     = $urandom_range(65535);
      c.torque_limit = $urandom_range(524287);
      c.goal_limit   = $urandom_range(524287);
      drain_and_settle();
      load_settings(c);
      send_idle_pct = $urandom_range(40);
      recv_idle_pct = $urandom_range(40);
      run_random(100, 1'b0);
    end
  endtask

  // Halt is sticky until reset, so it closes the run; no idling here.
  task automatic test_halt();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_item(make_item(KIND_KEY, $urandom_range(1) ? KEY_STOP_LO : KEY_STOP_UP, 0, 0, 0));
    run_random(100, 1'b1);
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    cmd.valid    = 1'b0;
    cmd.kind     = KIND_KEY;
    cmd.key_code = '0;
    cmd.joint    = '0;
    cmd.position = '0;
    cmd.velocity = '0;

    // Model starts from the block's reset state.
    active_cfg = '{8192, 2048, 6554, 655, 1966, 327680, 205887};
    for (int i = 0; i < JOINTS; i++) begin
      goal_q[i]        = '0;
      smooth_goal_q[i] = '0;
      filt_torque_q[i] = '0;
    end
    halted_q = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed_defaults();
    test_random_defaults();
    test_zero_settings();
    test_max_settings();
    test_alpha_above_one();
    test_random_settings();
    test_halt();

    drain_and_settle();
    if (torque_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/pdj_pkg.sv
rtl/core/pdj_item_if.sv
rtl/core/pdj_result_if.sv
rtl/core/joint_pd_torque_with_jog_goals.sv
rtl/core/pdj_checker.sv
test/joint_pd_torque_with_jog_goals_test.sv
